// ----- rtl/iirdf_pkg.sv -----
// Shared types, widths and register indexes of the direct-form-I IIR filter.
package iirdf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 16;
    localparam int HIST_DEPTH      = 3;
    localparam int NUM_FEEDFORWARD = 4;
    localparam int NUM_FEEDBACK    = 4;
    localparam int NUM_REGS        = 7;
    localparam int REG_IDX_W       = $clog2(NUM_REGS);
    localparam int PROD_W          = SAMPLE_W + COEF_W;
    // Seven products at most, plus headroom.
    localparam int ACC_W           = PROD_W + 4;
    localparam int FRAC_SHIFT      = 14;
    localparam int RND_W           = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RND_W-1:0]    rnd_t;

    localparam coef_t COEF_B0_RESET = coef_t'(16384);
    localparam acc_t  ROUND_HALF    = acc_t'(1) <<< (FRAC_SHIFT - 1);
    localparam rnd_t  SAMPLE_MAX    = rnd_t'(2**(SAMPLE_W-1) - 1);
    localparam rnd_t  SAMPLE_MIN    = -rnd_t'(2**(SAMPLE_W-1));

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_B3,
        REG_A1,
        REG_A2,
        REG_A3
    } reg_index_t;

endpackage

// ----- rtl/iir_difference_equation_filter.sv -----
// Third-order direct-form-I IIR filter with a streaming sample interface.
//
// Usage: samples arrive on the slave side (s_tdata = Q1.15 sample, s_tuser =
// start-of-block flag, which clears both histories before that sample).
// Filtered Q1.15 samples leave on the master side (m_tdata = sample,
// m_tuser = saturation flag), one result per request, in order.
// Coefficients (Q2.14, a0 taken as one) are written through cfg_we,
// cfg_index and cfg_data while the filter is idle; indexes b0..b3 are 0..3,
// a1..a3 are 4..6, and other indexes are ignored.
// Pipeline: an input register, a feedforward stage that forms the b-tap sum,
// and a feedback stage that adds the a-taps, rounds and saturates into the
// output register. Each accepted request passes these in order, and one
// sample is taken every cycle unless the output stalls. The feedback stage
// is the recurrence loop: three multipliers, a four-term sum, rounding and
// clamping. Reset restores b0 = 1.0, all other coefficients to zero, and
// clears both histories and all valid flags. When the receiver stalls, the
// output holds and the two stages behind it still fill before s_tready falls.
module iir_difference_equation_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [iirdf_pkg::SAMPLE_W-1:0]       s_tdata,   // [15:0] sample_in
    input  logic                                 s_tuser,   // [0] start_of_block
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [iirdf_pkg::SAMPLE_W-1:0]       m_tdata,   // [15:0] sample_out
    output logic                                 m_tuser,   // [0] saturated
    input  logic                                 cfg_we,
    input  logic [iirdf_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf_pkg::COEF_W-1:0]         cfg_data
);

    iirdf_pkg::coef_t   coef_b_reg [0:iirdf_pkg::HIST_DEPTH];
    iirdf_pkg::coef_t   coef_a_reg [1:iirdf_pkg::HIST_DEPTH];
    iirdf_pkg::sample_t x_hist_reg [0:iirdf_pkg::HIST_DEPTH-1];
    iirdf_pkg::sample_t y_hist_reg [0:iirdf_pkg::HIST_DEPTH-1];

    logic               s1_valid_reg;
    iirdf_pkg::sample_t s1_x_reg;
    logic               s1_sob_reg;

    logic               s2_valid_reg;
    iirdf_pkg::acc_t    s2_ff_reg;
    logic               s2_sob_reg;

    logic               out_valid_reg;
    iirdf_pkg::sample_t out_sample_reg;
    logic               out_sat_reg;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic s1_move;
    logic s2_move;

    iirdf_pkg::sample_t xh_eff [0:iirdf_pkg::HIST_DEPTH-1];
    iirdf_pkg::sample_t yh_eff [0:iirdf_pkg::HIST_DEPTH-1];
    iirdf_pkg::acc_t    ff_next;
    iirdf_pkg::acc_t    fb_acc;
    iirdf_pkg::rnd_t    y_rnd;
    iirdf_pkg::sample_t y_next;
    logic               sat_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s2_move   = s2_valid_reg && out_ready;

    assign s_tready = s1_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_sat_reg;

    // Feedforward sum; a start-of-block item sees an all-zero input history.
    always_comb
    begin
        iirdf_pkg::prod_t prod;
        for (int j = 0; j < iirdf_pkg::HIST_DEPTH; j++)
        begin
            xh_eff[j] = s1_sob_reg ? '0 : x_hist_reg[j];
        end
        ff_next = '0;
        if (iirdf_pkg::NUM_FEEDFORWARD > 0)
        begin
            prod    = iirdf_pkg::prod_t'(coef_b_reg[0]) * iirdf_pkg::prod_t'(s1_x_reg);
            ff_next = iirdf_pkg::acc_t'(prod);
        end
        for (int j = 1; j <= iirdf_pkg::HIST_DEPTH; j++)
        begin
            if (j < iirdf_pkg::NUM_FEEDFORWARD)
            begin
                prod    = iirdf_pkg::prod_t'(coef_b_reg[j]) * iirdf_pkg::prod_t'(xh_eff[j-1]);
                ff_next = ff_next + iirdf_pkg::acc_t'(prod);
            end
        end
    end

    // Feedback taps, round half up to Q1.15, then clamp.
    always_comb
    begin
        iirdf_pkg::prod_t prod;
        for (int j = 0; j < iirdf_pkg::HIST_DEPTH; j++)
        begin
            yh_eff[j] = s2_sob_reg ? '0 : y_hist_reg[j];
        end
        fb_acc = s2_ff_reg;
        for (int j = 1; j <= iirdf_pkg::HIST_DEPTH; j++)
        begin
            if (j < iirdf_pkg::NUM_FEEDBACK)
            begin
                prod   = iirdf_pkg::prod_t'(coef_a_reg[j]) * iirdf_pkg::prod_t'(yh_eff[j-1]);
                fb_acc = fb_acc - iirdf_pkg::acc_t'(prod);
            end
        end
        y_rnd = iirdf_pkg::rnd_t'((fb_acc + iirdf_pkg::ROUND_HALF) >>> iirdf_pkg::FRAC_SHIFT);
        if (y_rnd > iirdf_pkg::SAMPLE_MAX)
        begin
            y_next   = iirdf_pkg::sample_t'(iirdf_pkg::SAMPLE_MAX);
            sat_next = 1'b1;
        end
        else if (y_rnd < iirdf_pkg::SAMPLE_MIN)
        begin
            y_next   = iirdf_pkg::sample_t'(iirdf_pkg::SAMPLE_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            y_next   = iirdf_pkg::sample_t'(y_rnd);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b_reg[0] <= iirdf_pkg::COEF_B0_RESET;
            for (int j = 1; j <= iirdf_pkg::HIST_DEPTH; j++)
            begin
                coef_b_reg[j] <= '0;
                coef_a_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (iirdf_pkg::reg_index_t'(cfg_index))
                iirdf_pkg::REG_B0: coef_b_reg[0] <= cfg_data;
                iirdf_pkg::REG_B1: coef_b_reg[1] <= cfg_data;
                iirdf_pkg::REG_B2: coef_b_reg[2] <= cfg_data;
                iirdf_pkg::REG_B3: coef_b_reg[3] <= cfg_data;
                iirdf_pkg::REG_A1: coef_a_reg[1] <= cfg_data;
                iirdf_pkg::REG_A2: coef_a_reg[2] <= cfg_data;
                iirdf_pkg::REG_A3: coef_a_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < iirdf_pkg::HIST_DEPTH; j++)
            begin
                x_hist_reg[j] <= '0;
                y_hist_reg[j] <= '0;
            end
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            // Each history shifts when its stage hands an item on.
            if (s1_move)
            begin
                x_hist_reg[0] <= s1_x_reg;
                for (int j = 1; j < iirdf_pkg::HIST_DEPTH; j++)
                begin
                    x_hist_reg[j] <= xh_eff[j-1];
                end
            end
            if (s2_move)
            begin
                y_hist_reg[0] <= y_next;
                for (int j = 1; j < iirdf_pkg::HIST_DEPTH; j++)
                begin
                    y_hist_reg[j] <= yh_eff[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_x_reg   <= s_tdata;
            s1_sob_reg <= s_tuser;
        end
        if (s2_ready)
        begin
            s2_ff_reg  <= ff_next;
            s2_sob_reg <= s1_sob_reg;
        end
        if (out_ready)
        begin
            out_sample_reg <= y_next;
            out_sat_reg    <= sat_next;
        end
    end

endmodule

// ----- sim/iir_difference_equation_filter_test.sv -----
// Self-checking stream testbench for the third-order direct-form-I IIR filter.
module iir_difference_equation_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iirdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 552;
    localparam int LONG_HOLD_OFF  = 120;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(NUM_REGS);

    localparam sample_t X_MAX     = 16'sh7fff;
    localparam sample_t X_MIN     = 16'sh8000;
    localparam coef_t   COEF_MAX  = 16'sh7fff;
    localparam coef_t   COEF_MIN  = 16'sh8000;
    localparam coef_t   COEF_ZERO = 16'sh0000;
    localparam coef_t   COEF_HALF = 16'sd8192;

    typedef enum {TAPS_FULL, TAPS_MODERATE, TAPS_GENTLE} tap_range_t;

    typedef struct {
        sample_t value;
        logic    clipped;
    } filtered_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    // Predictor state: loaded coefficients and the two sample histories.
    coef_t     taps_now[NUM_REGS];
    sample_t   x_past[HIST_DEPTH];
    sample_t   y_past[HIST_DEPTH];
    filtered_t expected_samples[$];
    filtered_t want;

    int send_idle_pct = 31;
    int recv_idle_pct = 57;
    int hold_off_left = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;

    iir_difference_equation_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Difference equation over exact 64-bit sums, rounded half up and clamped.
    function automatic filtered_t filter_step(input sample_t x, input logic restart);
        longint    acc;
        longint    rounded;
        filtered_t res;
        if (restart)
        begin
            foreach (x_past[k])
            begin
                x_past[k] = '0;
                y_past[k] = '0;
            end
        end
        acc = longint'(taps_now[REG_B0]) * longint'(x);
        for (int j = 1; j <= HIST_DEPTH; j++)
        begin
            if (j < NUM_FEEDFORWARD)
                acc += longint'(taps_now[j]) * longint'(x_past[j-1]);
            if (j < NUM_FEEDBACK)
                acc -= longint'(taps_now[int'(REG_A1) + j - 1]) * longint'(y_past[j-1]);
        end
        rounded = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        res.clipped = 1'b0;
        if (rounded > longint'(SAMPLE_MAX))
        begin
            rounded = longint'(SAMPLE_MAX);
            res.clipped = 1'b1;
        end
        else if (rounded < longint'(SAMPLE_MIN))
        begin
            rounded = longint'(SAMPLE_MIN);
            res.clipped = 1'b1;
        end
        res.value = sample_t'(rounded);
        for (int k = HIST_DEPTH - 1; k > 0; k--)
        begin
            x_past[k] = x_past[k-1];
            y_past[k] = y_past[k-1];
        end
        x_past[0] = x;
        y_past[0] = res.value;
        return res;
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return sample_t'($urandom);
        if (pick < 75)
        begin
            case ($urandom_range(4))
                0:       return X_MAX;
                1:       return X_MIN;
                2:       return 16'sd1;
                3:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return sample_t'(int'($urandom_range(1024)) - 512);
    endfunction

    // Gentle feedback taps keep most outputs off the rails.
    function automatic coef_t random_tap(input tap_range_t span, input bit feedback);
        case (span)
            TAPS_FULL:     return coef_t'($urandom);
            TAPS_MODERATE: return coef_t'(int'($urandom_range(16384)) - 8192);
            default:
                if (feedback)
                    return coef_t'(int'($urandom_range(4096)) - 2048);
                else
                    return coef_t'(int'($urandom_range(12288)) - 6144);
        endcase
    endfunction

    task automatic send_sample(input sample_t x, input logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_samples.push_back(filter_step(x, restart));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_taps(input coef_t b0, input coef_t b1, input coef_t b2,
                             input coef_t b3, input coef_t a1, input coef_t a2,
                             input coef_t a3);
        coef_t taps[NUM_REGS];
        taps = '{b0, b1, b2, b3, a1, a2, a3};
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we      <= 1'b1;
            cfg_index   <= reg_index_t'(i);
            cfg_data    <= taps[i];
            taps_now[i] = taps[i];
            @(posedge clk);
        end
        // A write past the last register must leave every coefficient alone.
        cfg_index <= REG_UNUSED;
        cfg_data  <= coef_t'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
    endtask

    task automatic test_coef_extremes();
        drain_results();
        load_taps(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(X_MAX, 1'b1);
        send_sample(X_MAX, 1'b0);
        send_sample(X_MIN, 1'b0);
        send_sample(16'sd1, 1'b0);
        drain_results();
        load_taps(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(X_MIN, 1'b1);
        send_sample(X_MIN, 1'b0);
        send_sample(X_MAX, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    task automatic test_rounding_and_restart();
        drain_results();
        // A gain of one half puts odd inputs exactly on a rounding tie.
        load_taps(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO,
                  COEF_ZERO);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd3, 1'b0);
        drain_results();
        // An integrator runs into the rail through the feedback path, then a
        // start of block must wipe the saturated history.
        load_taps(COEF_B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO, -COEF_B0_RESET, COEF_ZERO,
                  COEF_ZERO);
        send_sample(16'sd20000, 1'b1);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    task automatic test_random_stream(input int sender_idle, input int receiver_idle);
        int sent;
        int run_len;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int span = 0; span < 3; span++)
        begin
            drain_results();
            load_taps(random_tap(tap_range_t'(span), 1'b0), random_tap(tap_range_t'(span), 1'b0),
                      random_tap(tap_range_t'(span), 1'b0), random_tap(tap_range_t'(span), 1'b0),
                      random_tap(tap_range_t'(span), 1'b1), random_tap(tap_range_t'(span), 1'b1),
                      random_tap(tap_range_t'(span), 1'b1));
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                run_len = $urandom_range(1, 48);
                for (int k = 0; k < run_len; k++)
                    send_sample(random_sample(), k == 0 || $urandom_range(99) < 3);
                sent += run_len;
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_results();
        load_taps(random_tap(TAPS_GENTLE, 1'b0), random_tap(TAPS_GENTLE, 1'b0),
                  random_tap(TAPS_GENTLE, 1'b0), random_tap(TAPS_GENTLE, 1'b0),
                  random_tap(TAPS_GENTLE, 1'b1), random_tap(TAPS_GENTLE, 1'b1),
                  random_tap(TAPS_GENTLE, 1'b1));
        hold_off_left = LONG_HOLD_OFF;
        for (int k = 0; k < 40; k++)
            send_sample(random_sample(), k == 0);
        // The sender stays quiet until the last result is out.
        drain_results();
        for (int k = 0; k < 10; k++)
            send_sample(random_sample(), 1'b0);
        drain_results();
    endtask

    // Receiver: long hold-off when requested, random stalls otherwise.
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: sample_out %0d saturated %0b",
                             $signed(m_tdata), m_tuser);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.clipped)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                                 want.value, $signed(m_tdata), want.clipped, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("iir_difference_equation_filter test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        foreach (taps_now[i])
            taps_now[i] = COEF_ZERO;
        taps_now[REG_B0] = COEF_B0_RESET;
        foreach (x_past[k])
        begin
            x_past[k] = '0;
            y_past[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_coef_extremes();
        test_rounding_and_restart();
        test_random_stream(31, 57);
        test_random_stream(57, 31);
        test_random_stream(0, 0);
        test_output_backpressure();

        drain_results();
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("iir_difference_equation_filter test passed");
        else
            $display("iir_difference_equation_filter test failed");
        $finish;
    end

endmodule

// ----- iir_difference_equation_filter.f -----
rtl/iirdf_pkg.sv
rtl/iir_difference_equation_filter.sv
sim/iir_difference_equation_filter_test.sv
